FILE: rtl/cpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_pkg
// Shared constants and types for the coherent pulse integrator.
// ----------------------------------------------------------------------------
package cpi_pkg;

  localparam int MAX_BINS    = 1024;
  localparam int MAX_PULSES  = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int ACC_BITS    = 24;

  localparam int BIN_W   = $clog2(MAX_BINS);    // bin counter / memory address
  localparam int PULSE_W = $clog2(MAX_PULSES);  // pulse counter
  localparam int NP_W    = 9;                   // num_pulses register
  localparam int NB_W    = 11;                  // num_bins register
  localparam int CFG_W   = 11;                  // widest register
  localparam int CFG_IDX_W = 1;

  localparam int IN_DATA_W  = 2 * SAMPLE_BITS;
  localparam int OUT_DATA_W = 64;               // 24 + 24 + 10 padded to bytes

  localparam logic [NP_W-1:0] NUM_PULSES_RST = NP_W'(32);
  localparam logic [NB_W-1:0] NUM_BINS_RST   = NB_W'(1024);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_NUM_PULSES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS   = 1'b1;

  // Control carried with a sample through the accumulate stage
  typedef struct packed {
    logic             first_pulse;
    logic             last_pulse;
    logic             last_bin;
    logic [BIN_W-1:0] bin;
  } cpi_ctrl_t;

endpackage

FILE: rtl/coherent_pulse_integrator_unit.sv
`timescale 1ns / 1ps
// Latency: a result is registered in the accumulate stage, then in the output register.
// Throughput: one sample per cycle, set by the single accumulator memory
// read-modify-write (read on accept, write as the sample leaves the accumulate stage, with forwarding); input
// stalls only while a result waits both here and in a stalled output register.
// Reset (rst_n low, synchronous) clears counters and valid flags, restores num_pulses = 32
// and num_bins = 1024, and keeps the accumulator memory, as pulse 0 loads every bin.
// ----------------------------------------------------------------------------
// coherent_pulse_integrator_unit
// Per-bin complex accumulation over pulses, emitting the sums on the last pulse.
// ----------------------------------------------------------------------------
module coherent_pulse_integrator_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write port
  input  logic                             cfg_we,
  input  logic [cpi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cpi_pkg::CFG_W-1:0]        cfg_wdata,
  // Sample stream; tdata: sample_real [15:0], sample_imag [31:16]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cpi_pkg::IN_DATA_W-1:0]    in_tdata,
  // Result stream; tdata: sum_real [23:0], sum_imag [47:24], bin_index [57:48],
  // zero fill [63:58]; tlast: last_bin
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cpi_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tlast
);

  import cpi_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers and their effective values
  // --------------------------------------------------------------------------
  logic [NP_W-1:0] num_pulses_r, num_pulses_nxt;
  logic [NB_W-1:0] num_bins_r,   num_bins_nxt;
  logic [NP_W-1:0] np_eff;
  logic [NB_W-1:0] nb_eff;

  always_comb begin
    num_pulses_nxt = num_pulses_r;
    num_bins_nxt   = num_bins_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_PULSES: num_pulses_nxt = cfg_wdata[NP_W-1:0];
        REG_NUM_BINS:   num_bins_nxt   = cfg_wdata[NB_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one; anything above the maximum saturates
  always_comb begin
    if (num_pulses_r == '0) begin
      np_eff = NP_W'(1);
    end else if (num_pulses_r > NP_W'(MAX_PULSES)) begin
      np_eff = NP_W'(MAX_PULSES);
    end else begin
      np_eff = num_pulses_r;
    end
    if (num_bins_r == '0) begin
      nb_eff = NB_W'(1);
    end else if (num_bins_r > NB_W'(MAX_BINS)) begin
      nb_eff = NB_W'(MAX_BINS);
    end else begin
      nb_eff = num_bins_r;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and stage control
  // --------------------------------------------------------------------------
  logic      in_accept;
  logic      s1_valid_r, s1_valid_nxt;
  cpi_ctrl_t s1_ctrl_r;
  logic      s1_adv;
  logic      out_free;
  logic      out_load;
  logic      out_valid_r, out_valid_nxt;

  // Output register frees up when empty or when its transaction completes
  assign out_free  = !out_valid_r || out_tready;
  // Accumulate stage moves on unless it holds a result with nowhere to go
  assign s1_adv    = s1_valid_r && (!s1_ctrl_r.last_pulse || out_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;
  assign out_load  = s1_adv && s1_ctrl_r.last_pulse;

  assign s1_valid_nxt  = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  // --------------------------------------------------------------------------
  // Bin and pulse counters
  // --------------------------------------------------------------------------
  logic [BIN_W-1:0]   bin_count_r,   bin_count_nxt;
  logic [PULSE_W-1:0] pulse_count_r, pulse_count_nxt;
  logic               cur_first, cur_last_pulse, cur_last_bin;

  assign cur_first      = (pulse_count_r == '0);
  assign cur_last_pulse = ((NP_W'(pulse_count_r) + NP_W'(1)) == np_eff);
  assign cur_last_bin   = ((NB_W'(bin_count_r) + NB_W'(1)) == nb_eff);

  always_comb begin
    bin_count_nxt   = bin_count_r;
    pulse_count_nxt = pulse_count_r;
    priority if (cfg_we) begin
      // Any register write restarts the integration
      bin_count_nxt   = '0;
      pulse_count_nxt = '0;
    end else if (in_accept) begin
      if (cur_last_bin) begin
        bin_count_nxt   = '0;
        pulse_count_nxt = cur_last_pulse ? '0 : pulse_count_r + PULSE_W'(1);
      end else begin
        bin_count_nxt = bin_count_r + BIN_W'(1);
      end
    end else begin
      // Hold the position while no transaction arrives
      bin_count_nxt   = bin_count_r;
      pulse_count_nxt = pulse_count_r;
    end
  end

  // --------------------------------------------------------------------------
  // Accumulate stage
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] s1_re_r, s1_im_r;
  logic [2*ACC_BITS-1:0]         mem_rd_r;
  logic [2*ACC_BITS-1:0]         fwd_data_r;
  logic                          fwd_r;
  logic [ACC_BITS-1:0]           acc_re_c, acc_im_c;
  logic [ACC_BITS-1:0]           ext_re_c, ext_im_c;
  logic [ACC_BITS-1:0]           sum_re_c, sum_im_c;

  // Accumulator memory: no reset, each bin is loaded on pulse 0
  logic [2*ACC_BITS-1:0] acc_mem [MAX_BINS];

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      acc_mem[s1_ctrl_r.bin] <= {sum_im_c, sum_re_c};
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mem_rd_r <= acc_mem[bin_count_r];
    end
  end

  // Sign-extend the sample to accumulator width
  assign ext_re_c = ACC_BITS'(s1_re_r);
  assign ext_im_c = ACC_BITS'(s1_im_r);

  // Take the just-written sum when the write lands on the bin being read
  assign acc_re_c = fwd_r ? fwd_data_r[ACC_BITS-1:0]          : mem_rd_r[ACC_BITS-1:0];
  assign acc_im_c = fwd_r ? fwd_data_r[2*ACC_BITS-1:ACC_BITS] : mem_rd_r[2*ACC_BITS-1:ACC_BITS];

  assign sum_re_c = s1_ctrl_r.first_pulse ? ext_re_c : acc_re_c + ext_re_c;
  assign sum_im_c = s1_ctrl_r.first_pulse ? ext_im_c : acc_im_c + ext_im_c;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_re_r               <= in_tdata[SAMPLE_BITS-1:0];
      s1_im_r               <= in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      s1_ctrl_r.first_pulse <= cur_first;
      s1_ctrl_r.last_pulse  <= cur_last_pulse;
      s1_ctrl_r.last_bin    <= cur_last_bin;
      s1_ctrl_r.bin         <= bin_count_r;
      fwd_data_r            <= {sum_im_c, sum_re_c};
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [ACC_BITS-1:0] sum_real_r, sum_imag_r;
  logic [BIN_W-1:0]    bin_index_r;
  logic                last_bin_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      sum_real_r  <= sum_re_c;
      sum_imag_r  <= sum_im_c;
      bin_index_r <= s1_ctrl_r.bin;
      last_bin_r  <= s1_ctrl_r.last_bin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({bin_index_r, sum_imag_r, sum_real_r});
  assign out_tlast  = last_bin_r;

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_pulses_r  <= NUM_PULSES_RST;
      num_bins_r    <= NUM_BINS_RST;
      bin_count_r   <= '0;
      pulse_count_r <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      fwd_r         <= 1'b0;
    end else begin
      num_pulses_r  <= num_pulses_nxt;
      num_bins_r    <= num_bins_nxt;
      bin_count_r   <= bin_count_nxt;
      pulse_count_r <= pulse_count_nxt;
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      if (in_accept) begin
        fwd_r <= s1_adv && (s1_ctrl_r.bin == bin_count_r);
      end
    end
  end

endmodule

FILE: rtl/cpi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_checker
// Port-level checks on the coherent pulse integrator, bound to the top level.
// ----------------------------------------------------------------------------
module cpi_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             cfg_we,
  input logic [cpi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [cpi_pkg::CFG_W-1:0]        cfg_wdata,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [cpi_pkg::IN_DATA_W-1:0]    in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [cpi_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic                             out_tlast
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A fresh result follows a sample transaction through the accumulate stage and output registers
  a_rise_from_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !$past(out_tvalid) |-> $past(rst_n && in_tvalid && in_tready, 2))
    else $error("result without a preceding sample");

  // After the final bin of a vector the next result is bin zero
  a_vector_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid || (out_tdata[57:48] == 10'd0))
    else $error("output vector did not restart at bin zero");

endmodule

bind coherent_pulse_integrator_unit cpi_checker u_cpi_checker (.*);
